// ===== src/eight_channel_sample_mixer_unit_defines.svh =====
// Assertion macros for the sample mixer unit.
`ifndef EIGHT_CHANNEL_SAMPLE_MIXER_UNIT_DEFINES_SVH
`define EIGHT_CHANNEL_SAMPLE_MIXER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SMU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smu check failed");
// next-cycle implication
`define SMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smu check failed");
`else
`define SMU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SMU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/smu_pkg.sv =====
// Shared types, constants and the volume table for the sample mixer unit.
`default_nettype none

package smu_pkg;

    localparam int DEF_NUM_CHANNELS = 8;
    localparam int DEF_NUM_LEVELS   = 8;
    localparam int DEF_LENGTH_BITS  = 24;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 13;               // Q.12 table entry, max 4096
    localparam int LEVEL_W     = 3;
    localparam int VOL_W       = 8;
    localparam int START_LEN_W = 24;
    localparam int PROD_W      = 17;               // table entry * (level+1)
    localparam int CH_GAIN_W   = 17;
    localparam int TERM_W      = SAMPLE_W + CH_GAIN_W + 1;
    localparam int MPROD_W     = 32;
    localparam int SUM_W       = TERM_W + 4;
    localparam int FRAC_BITS   = 12;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 24;
    localparam int ROM_DEPTH   = 256;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int USED_W      = 8;

    typedef enum logic [1:0] {
        OP_MIX     = 2'd0,
        OP_START   = 2'd1,
        OP_SILENCE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MUSIC_VOLUME   = 2'd0,
        CFG_SAMPLE_VOLUME  = 2'd1,
        CFG_MUSIC_ENABLE   = 2'd2,
        CFG_SAMPLES_ENABLE = 2'd3
    } cfg_idx_t;

    // load strobes for the six datapath stages
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    // per-lane command decoded from the accepted item
    typedef struct packed {
        logic mix;
        logic start;
        logic silence;
        logic samples_en;
    } lane_cmd_t;

    typedef logic [GAIN_W-1:0] vol_rom_t [ROM_DEPTH];

    localparam logic [63:0] Q_ONE   = 64'd1 << 62;
    localparam logic [63:0] Q_TENTH = Q_ONE / 64'd10;
    localparam logic [63:0] LO32    = 64'h0000_0000_FFFF_FFFF;

    // Q2.62 unsigned product
    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = a & LO32;
        ah  = a >> 32;
        bl  = b & LO32;
        bh  = b >> 32;
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + (lh & LO32) + (hl & LO32);
        lo  = (ll & LO32) | (mid << 32);
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return (hi << 2) | (lo >> 62);
    endfunction

    function automatic logic [63:0] qpow(input logic [63:0] r, input int n);
        logic [63:0] p;
        p = Q_ONE;
        for (int i = 0; i < n; i++) begin
            p = qmul(p, r);
        end
        return p;
    endfunction

    // 30 dB table: step ratio found by bisection on r^170 = 0.1
    function automatic vol_rom_t build_vol_rom();
        vol_rom_t    rom;
        logic [63:0] lo, hi, m, p;
        lo = 64'd0;
        hi = Q_ONE;
        while ((hi - lo) > 64'd1) begin
            m = lo + ((hi - lo) >> 1);
            if (qpow(m, 170) <= Q_TENTH) begin
                lo = m;
            end else begin
                hi = m;
            end
        end
        p = Q_ONE;
        rom[0] = '0;
        for (int k = 0; k < ROM_DEPTH - 1; k++) begin
            rom[ROM_DEPTH - 1 - k] = GAIN_W'(p >> (62 - FRAC_BITS));
            p = qmul(p, lo);
        end
        return rom;
    endfunction

    localparam vol_rom_t VOL_ROM = build_vol_rom();

endpackage

`default_nettype wire

// ===== src/smu_if.sv =====
// Item channel interfaces of the sample mixer unit.
`default_nettype none

interface smu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [15:0] music_sample;
    logic [63:0] channel_samples_low;
    logic [63:0] channel_samples_high;
    logic [2:0]  start_channel;
    logic [23:0] start_length;
    logic [2:0]  start_level;

    modport source (
        output valid, operation, music_sample, channel_samples_low,
               channel_samples_high, start_channel, start_length, start_level,
        input  ready
    );
    modport sink (
        input  valid, operation, music_sample, channel_samples_low,
               channel_samples_high, start_channel, start_length, start_level,
        output ready
    );
endinterface

interface smu_res_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] mixed_sample;
    logic [7:0]  channels_used;

    modport source (output valid, mixed_sample, channels_used, input ready);
    modport sink   (input valid, mixed_sample, channels_used, output ready);
endinterface

`default_nettype wire

// ===== src/smu_lane.sv =====
// One channel lane: length counter, level, and gain/scale pipeline.
`default_nettype none

module smu_lane #(
    parameter int NUM_LEVELS  = smu_pkg::DEF_NUM_LEVELS,
    parameter int LENGTH_BITS = smu_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire smu_pkg::lane_cmd_t                     cmd,
    input  wire smu_pkg::stage_en_t                     en,
    input  wire logic [LENGTH_BITS-1:0]                 start_length,
    input  wire logic [smu_pkg::LEVEL_W-1:0]            start_level,
    input  wire logic signed [smu_pkg::SAMPLE_W-1:0]    sample,
    input  wire logic [smu_pkg::GAIN_W-1:0]             base,
    output logic                                        active,
    output logic signed [smu_pkg::TERM_W-1:0]           term
);

    // x / NUM_LEVELS as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^PROD_W
    localparam logic [smu_pkg::RECIP_W-1:0] RECIP =
        smu_pkg::RECIP_W'(((64'd1 << smu_pkg::RECIP_SHIFT) + 64'(NUM_LEVELS) - 64'd1)
                          / 64'(NUM_LEVELS));
    localparam int SCALED_W = smu_pkg::PROD_W + smu_pkg::RECIP_W;

    logic [LENGTH_BITS-1:0]              remaining_reg, remaining_next;
    logic [smu_pkg::LEVEL_W-1:0]         level_reg, level_next;

    logic signed [smu_pkg::SAMPLE_W-1:0] smp1_reg, smp2_reg, smp3_reg;
    logic [smu_pkg::LEVEL_W-1:0]         lvl1_reg;
    logic [smu_pkg::PROD_W-1:0]          prod2_reg;
    logic [smu_pkg::CH_GAIN_W-1:0]       gain3_reg;
    logic signed [smu_pkg::TERM_W-1:0]   term4_reg;
    logic [SCALED_W-1:0]                 scaled;

    assign active = cmd.samples_en && (remaining_reg != '0);

    always_comb
    begin
        remaining_next = remaining_reg;
        level_next     = level_reg;
        if (cmd.silence)
        begin
            remaining_next = '0;
        end
        else if (cmd.start)
        begin
            remaining_next = start_length;
            level_next     = start_level;
        end
        else if (cmd.mix && active)
        begin
            remaining_next = remaining_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            level_reg     <= '0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            level_reg     <= level_next;
        end
    end

    assign scaled = SCALED_W'(prod2_reg) * SCALED_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            smp1_reg <= active ? sample : '0;
            lvl1_reg <= level_reg;
        end
        if (en.s2)
        begin
            prod2_reg <= smu_pkg::PROD_W'(base) *
                         smu_pkg::PROD_W'({1'b0, lvl1_reg} + 4'd1);
            smp2_reg  <= smp1_reg;
        end
        if (en.s3)
        begin
            gain3_reg <= scaled[SCALED_W-1:smu_pkg::RECIP_SHIFT];
            smp3_reg  <= smp2_reg;
        end
        if (en.s4)
        begin
            term4_reg <= smu_pkg::TERM_W'(smp3_reg) *
                         smu_pkg::TERM_W'($signed({1'b0, gain3_reg}));
        end
    end

    assign term = term4_reg;

endmodule

`default_nettype wire

// ===== src/smu_merge.sv =====
// Music path, lane summation, floor shift and saturation to 16 bits.
`default_nettype none

module smu_merge #(
    parameter int NUM_CHANNELS = smu_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                                  clk,
    input  wire smu_pkg::stage_en_t                    en,
    input  wire logic                                  music_enable,
    input  wire logic [smu_pkg::VOL_W-1:0]             music_volume,
    input  wire logic signed [smu_pkg::SAMPLE_W-1:0]   music_sample,
    input  wire logic [NUM_CHANNELS-1:0]               used,
    input  wire logic signed [smu_pkg::TERM_W-1:0]     terms [NUM_CHANNELS],
    output logic signed [smu_pkg::SAMPLE_W-1:0]        mixed_sample,
    output logic [smu_pkg::USED_W-1:0]                 channels_used
);

    localparam int SHIFT_W = smu_pkg::SUM_W - smu_pkg::FRAC_BITS;

    logic signed [smu_pkg::SAMPLE_W-1:0] music1_reg;
    logic [smu_pkg::GAIN_W-1:0]          mgain1_reg;
    logic signed [smu_pkg::MPROD_W-1:0]  mprod2_reg, mprod3_reg, mprod4_reg;
    logic [NUM_CHANNELS-1:0]             used1_reg, used2_reg, used3_reg, used4_reg, used5_reg;
    logic signed [smu_pkg::SUM_W-1:0]    sum_next, sum5_reg;
    logic signed [SHIFT_W-1:0]           shifted;
    logic [SHIFT_W-smu_pkg::SAMPLE_W:0]  top_bits;
    logic signed [smu_pkg::SAMPLE_W-1:0] sat;
    logic signed [smu_pkg::SAMPLE_W-1:0] mixed_reg;
    logic [smu_pkg::USED_W-1:0]          used_out_reg;

    always_comb
    begin
        sum_next = smu_pkg::SUM_W'(mprod4_reg);
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            sum_next = sum_next + smu_pkg::SUM_W'(terms[c]);
        end
    end

    // arithmetic shift is floor division by 4096
    assign shifted  = sum5_reg[smu_pkg::SUM_W-1:smu_pkg::FRAC_BITS];
    assign top_bits = shifted[SHIFT_W-1:smu_pkg::SAMPLE_W-1];

    always_comb
    begin
        if ((top_bits == '0) || (top_bits == '1))
        begin
            sat = shifted[smu_pkg::SAMPLE_W-1:0];
        end
        else if (shifted[SHIFT_W-1])
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = 16'sh7FFF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            music1_reg <= music_enable ? music_sample : '0;
            mgain1_reg <= smu_pkg::VOL_ROM[music_volume];
            used1_reg  <= used;
        end
        if (en.s2)
        begin
            // music gain is the table entry doubled
            mprod2_reg <= smu_pkg::MPROD_W'(music1_reg) *
                          smu_pkg::MPROD_W'($signed({2'b00, mgain1_reg, 1'b0}));
            used2_reg  <= used1_reg;
        end
        if (en.s3)
        begin
            mprod3_reg <= mprod2_reg;
            used3_reg  <= used2_reg;
        end
        if (en.s4)
        begin
            mprod4_reg <= mprod3_reg;
            used4_reg  <= used3_reg;
        end
        if (en.s5)
        begin
            sum5_reg  <= sum_next;
            used5_reg <= used4_reg;
        end
        if (en.s6)
        begin
            mixed_reg    <= sat;
            used_out_reg <= smu_pkg::USED_W'(used5_reg);
        end
    end

    assign mixed_sample  = mixed_reg;
    assign channels_used = used_out_reg;

endmodule

`default_nettype wire

// ===== src/eight_channel_sample_mixer_unit.sv =====
// After acceptance a mix item passes four lane stages, a sum stage and a saturate stage.
// Throughput: one item per cycle unless a result stalls; start, silence and unused give no result.
// The rate is set by the per-channel lanes, each a multiply pipeline, and one summing stage.
// Reset (rst_n, async, active low): all channels idle, levels 0, volumes 255,
// music disabled, samples enabled, pipeline empty. No clearing pass is needed.
`default_nettype none

`include "eight_channel_sample_mixer_unit_defines.svh"

module eight_channel_sample_mixer_unit #(
    parameter int NUM_CHANNELS = smu_pkg::DEF_NUM_CHANNELS,
    parameter int NUM_LEVELS   = smu_pkg::DEF_NUM_LEVELS,
    parameter int LENGTH_BITS  = smu_pkg::DEF_LENGTH_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    smu_req_if.sink                                request,
    smu_res_if.source                              result,
    input  wire logic                              cfg_we,
    input  wire logic [smu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smu_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NSTAGE = 6;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [smu_pkg::VOL_W-1:0] music_volume_reg, sample_volume_reg;
    logic                      music_enable_reg, samples_enable_reg;
    smu_pkg::cfg_idx_t         cfg_idx;

    assign cfg_idx = smu_pkg::cfg_idx_t'(cfg_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            music_volume_reg   <= 8'd255;
            sample_volume_reg  <= 8'd255;
            music_enable_reg   <= 1'b0;
            samples_enable_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                smu_pkg::CFG_MUSIC_VOLUME:   music_volume_reg   <= cfg_data;
                smu_pkg::CFG_SAMPLE_VOLUME:  sample_volume_reg  <= cfg_data;
                smu_pkg::CFG_MUSIC_ENABLE:   music_enable_reg   <= cfg_data[0];
                smu_pkg::CFG_SAMPLES_ENABLE: samples_enable_reg <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // moves, so bubbles collapse and a held result does not block input
    // until every stage is full.
    // ------------------------------------------------------------------
    logic [NSTAGE:1] v_reg, v_next;
    logic [NSTAGE:1] adv;
    smu_pkg::stage_en_t en;
    smu_pkg::op_t       op;
    logic               req_acc, mix_acc;

    assign op      = smu_pkg::op_t'(request.operation);
    assign req_acc = request.valid && request.ready;
    assign mix_acc = req_acc && (op == smu_pkg::OP_MIX);

    always_comb
    begin
        adv[NSTAGE] = !v_reg[NSTAGE] || result.ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign request.ready = adv[1];

    always_comb
    begin
        v_next    = v_reg;
        v_next[1] = adv[1] ? mix_acc : v_reg[1];
        for (int k = 2; k <= NSTAGE; k++)
        begin
            if (adv[k])
            begin
                v_next[k] = v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign en = '{s1: adv[1], s2: adv[2], s3: adv[3], s4: adv[4], s5: adv[5], s6: adv[6]};

    // ------------------------------------------------------------------
    // Start decode: level saturates to the top level, length wraps to
    // LENGTH_BITS.
    // ------------------------------------------------------------------
    logic [smu_pkg::LEVEL_W-1:0] start_level_sat;
    logic [LENGTH_BITS-1:0]      start_length_w;
    logic [smu_pkg::GAIN_W-1:0]  base_reg;
    logic [16*8-1:0]             all_samples;
    logic [NUM_CHANNELS-1:0]     active_vec;
    logic signed [smu_pkg::TERM_W-1:0] terms [NUM_CHANNELS];

    always_comb
    begin
        if (32'(request.start_level) >= NUM_LEVELS)
        begin
            start_level_sat = smu_pkg::LEVEL_W'(NUM_LEVELS - 1);
        end
        else
        begin
            start_level_sat = request.start_level;
        end
    end

    assign start_length_w = LENGTH_BITS'(request.start_length);
    assign all_samples    = {request.channel_samples_high, request.channel_samples_low};

    // channel base gain, shared by all lanes from stage 2 on
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            base_reg <= smu_pkg::VOL_ROM[sample_volume_reg];
        end
    end

    // ------------------------------------------------------------------
    // Channel lanes
    // ------------------------------------------------------------------
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_lane
        smu_pkg::lane_cmd_t cmd;

        assign cmd.mix        = mix_acc;
        assign cmd.start      = req_acc && (op == smu_pkg::OP_START) && samples_enable_reg
                                && (request.start_channel == 3'(c));
        assign cmd.silence    = req_acc && (op == smu_pkg::OP_SILENCE);
        assign cmd.samples_en = samples_enable_reg;

        smu_lane #(
            .NUM_LEVELS  (NUM_LEVELS),
            .LENGTH_BITS (LENGTH_BITS)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .cmd          (cmd),
            .en           (en),
            .start_length (start_length_w),
            .start_level  (start_level_sat),
            .sample       ($signed(all_samples[16*c +: 16])),
            .base         (base_reg),
            .active       (active_vec[c]),
            .term         (terms[c])
        );
    end

    // ------------------------------------------------------------------
    // Merge: music term, lane sum, shift and saturate, output register
    // ------------------------------------------------------------------
    smu_merge #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_merge (
        .clk           (clk),
        .en            (en),
        .music_enable  (music_enable_reg),
        .music_volume  (music_volume_reg),
        .music_sample  (request.music_sample),
        .used          (active_vec),
        .terms         (terms),
        .mixed_sample  (result.mixed_sample),
        .channels_used (result.channels_used)
    );

    assign result.valid = v_reg[NSTAGE];

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // a silence leaves every channel idle
    `SMU_ASSERT_NEXT(a_silence_idle, clk, rst_n,
        req_acc && (op == smu_pkg::OP_SILENCE), active_vec == '0)
    // disabled samples never count as active
    `SMU_ASSERT_SAME(a_disabled_idle, clk, rst_n, !samples_enable_reg, active_vec == '0)
    // input is held off only by a stalled result
    `SMU_ASSERT_SAME(a_stall_cause, clk, rst_n, !request.ready,
        result.valid && !result.ready)
    // a result appears only from a filled last-but-one stage
    `SMU_ASSERT_NEXT(a_no_phantom, clk, rst_n,
        !v_reg[NSTAGE-1] && !v_reg[NSTAGE], !v_reg[NSTAGE])

endmodule

`default_nettype wire

// ===== tb/eight_channel_sample_mixer_unit_tb.sv =====
// Self-checking testbench for the eight-channel sample mixer unit: directed and random items.
module eight_channel_sample_mixer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS      = 8;
    localparam int LEVELS        = 8;
    localparam int SETTLE_CYCLES = 12;     // pipeline is 6 deep, allow a margin
    localparam int STALL_LIMIT   = 5000;   // cycles with work outstanding and no handshake
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 113;

    // one request item as the predictor sees it
    typedef struct {
        smu_pkg::op_t       op;
        logic signed [15:0] music;
        logic [63:0]        lanes_lo;   // channels 0-3, channel 0 in the low bits
        logic [63:0]        lanes_hi;   // channels 4-7
        logic [2:0]         channel;
        logic [23:0]        length;
        logic [2:0]         level;
    } mixer_cmd_t;

    typedef struct {
        logic signed [15:0] sample;
        logic [7:0]         used;
    } mix_result_t;

    // receiver stall styles, each held for a random stretch of cycles
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    logic                           clk   = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we;
    logic [smu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [smu_pkg::CFG_DATA_W-1:0] cfg_data;

    smu_req_if req_ch();
    smu_res_if res_ch();

    eight_channel_sample_mixer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (req_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: gain table, register copies, per-channel state
    // ---------------------------------------------------------------
    int unsigned gain_rom [256];
    logic [7:0]  music_vol;
    logic [7:0]  sample_vol;
    logic        music_on;
    logic        samples_on;
    logic [23:0] left_count [CHANNELS];
    logic [2:0]  lane_level [CHANNELS];

    mixer_cmd_t  cmd_queue [$];   // items waiting for the driver
    mix_result_t mix_queue [$];   // mix results still owed by the block

    int          errors = 0;
    logic        req_taken = 1'b0;
    int          stall_cycles = 0;

    // driver and receiver pacing
    int          burst_left = 1;
    int          gap_left = 0;
    rx_style_t   rx_style = RX_OPEN;
    int          rx_left = 0;

    // Q2.62 unsigned product, truncated
    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] full;
        full = a * b;
        return full[125:62];
    endfunction

    function automatic logic [63:0] q62_pow(input logic [63:0] base, input int n);
        logic [63:0] acc;
        acc = 64'd1 << 62;
        for (int i = 0; i < n; i++)
        begin
            acc = q62_mul(acc, base);
        end
        return acc;
    endfunction

    // 30 dB gain table: the per-step ratio is the largest r with r^170 <= 0.1,
    // then successive powers of r fill the table downwards from unity.
    function automatic void fill_gain_rom();
        logic [63:0] unity, tenth, lo_r, hi_r, mid_r, step;
        unity = 64'd1 << 62;
        tenth = unity / 64'd10;
        lo_r  = '0;
        hi_r  = unity;
        while (hi_r - lo_r > 64'd1)
        begin
            mid_r = lo_r + (hi_r - lo_r) / 64'd2;
            if (q62_pow(mid_r, 170) <= tenth)
                lo_r = mid_r;
            else
                hi_r = mid_r;
        end
        step = unity;
        gain_rom[0] = 0;
        for (int k = 255; k >= 1; k--)
        begin
            gain_rom[k] = int'(step >> 50);
            step = q62_mul(step, lo_r);
        end
    endfunction

    // Works out what one accepted item does to the channel state and,
    // for a mix, the result the block owes.
    function automatic void apply_command(input mixer_cmd_t cmd);
        longint             acc;
        longint             scaled;
        longint unsigned    gain;
        logic [63:0]        word;
        logic signed [15:0] lane;
        mix_result_t        owed;
        case (cmd.op)
            smu_pkg::OP_START:
            begin
                // starts are dropped while samples are off; a level can never
                // exceed the top step here, as the field has exactly 8 codes
                if (samples_on)
                begin
                    left_count[cmd.channel] = cmd.length;
                    lane_level[cmd.channel] = cmd.level;
                end
            end
            smu_pkg::OP_SILENCE:
            begin
                // clears every channel whatever samples_enable says
                for (int c = 0; c < CHANNELS; c++)
                begin
                    left_count[c] = '0;
                end
            end
            smu_pkg::OP_MIX:
            begin
                acc = 0;
                owed.used = '0;
                if (music_on)
                    acc = longint'(cmd.music) * longint'(2 * gain_rom[music_vol]);
                if (samples_on)
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (left_count[c] != '0)
                        begin
                            word = (c < 4) ? cmd.lanes_lo : cmd.lanes_hi;
                            lane = word[16*(c%4) +: 16];
                            gain = (gain_rom[sample_vol] * (lane_level[c] + 32'd1)) / LEVELS;
                            acc += longint'(lane) * longint'(gain);
                            left_count[c] = left_count[c] - 24'd1;
                            owed.used[c] = 1'b1;
                        end
                    end
                end
                // arithmetic shift gives the floor, then clamp to 16 bits
                scaled = acc >>> 12;
                if (scaled > 32767)
                    scaled = 32767;
                else if (scaled < -32768)
                    scaled = -32768;
                owed.sample = 16'(scaled);
                mix_queue.push_back(owed);
            end
            default:
            begin
                // unused code: no effect, no result
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Item builders
    // ---------------------------------------------------------------
    // every field random but the operation (a mix), so unused fields carry noise too
    function automatic mixer_cmd_t rand_cmd();
        mixer_cmd_t c;
        c.op       = smu_pkg::OP_MIX;
        c.music    = 16'($urandom);
        c.lanes_lo = {$urandom, $urandom};
        c.lanes_hi = {$urandom, $urandom};
        c.channel  = 3'($urandom_range(0, 7));
        c.length   = 24'($urandom);
        c.level    = 3'($urandom_range(0, 7));
        return c;
    endfunction

    function automatic void queue_mix(input logic signed [15:0] music,
                                      input logic [63:0] lo, input logic [63:0] hi);
        mixer_cmd_t c;
        c = rand_cmd();
        c.music    = music;
        c.lanes_lo = lo;
        c.lanes_hi = hi;
        cmd_queue.push_back(c);
    endfunction

    function automatic void queue_start(input int channel, input logic [23:0] length,
                                        input int level);
        mixer_cmd_t c;
        c = rand_cmd();
        c.op      = smu_pkg::OP_START;
        c.channel = 3'(channel);
        c.length  = length;
        c.level   = 3'(level);
        cmd_queue.push_back(c);
    endfunction

    function automatic void queue_op(input smu_pkg::op_t op);
        mixer_cmd_t c;
        c = rand_cmd();
        c.op = op;
        cmd_queue.push_back(c);
    endfunction

    // mostly short plays so channels run out and get restarted
    function automatic logic [23:0] pick_length();
        case ($urandom_range(0, 15))
            0:       return 24'd0;
            1:       return 24'hFF_FFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(1, 12));
        endcase
    endfunction

    // Random traffic: mostly arm-then-play episodes, the rest stray commands.
    function automatic void queue_random(input int budget);
        int         made;
        int         n;
        mixer_cmd_t c;
        made = 0;
        while (made < budget)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                n = $urandom_range(1, 4);
                repeat (n)
                begin
                    c = rand_cmd();
                    c.op = smu_pkg::OP_START;
                    c.length = pick_length();
                    cmd_queue.push_back(c);
                    made++;
                end
                n = $urandom_range(1, 16);
                repeat (n)
                begin
                    c = rand_cmd();
                    case ($urandom_range(0, 11))
                        0:
                        begin
                            // drive the sum hard into the top clamp
                            c.music    = 16'sh7FFF;
                            c.lanes_lo = {4{16'h7FFF}};
                            c.lanes_hi = {4{16'h7FFF}};
                        end
                        1:
                        begin
                            c.music    = 16'sh8000;
                            c.lanes_lo = {4{16'h8000}};
                            c.lanes_hi = {4{16'h8000}};
                        end
                        default:
                        begin
                        end
                    endcase
                    cmd_queue.push_back(c);
                    made++;
                end
            end
            else
            begin
                c = rand_cmd();
                case ($urandom_range(0, 3))
                    0:       c.op = smu_pkg::OP_SILENCE;
                    1:       c.op = smu_pkg::OP_NONE;
                    default: c.op = smu_pkg::OP_MIX;
                endcase
                cmd_queue.push_back(c);
                if (c.op != smu_pkg::OP_NONE)
                    made++;
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Configuration and phase control
    // ---------------------------------------------------------------
    task automatic set_reg(input smu_pkg::cfg_idx_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= smu_pkg::CFG_DATA_W'(value);
        case (idx)
            smu_pkg::CFG_MUSIC_VOLUME:   music_vol  = 8'(value);
            smu_pkg::CFG_SAMPLE_VOLUME:  sample_vol = 8'(value);
            smu_pkg::CFG_MUSIC_ENABLE:   music_on   = 1'(value);
            smu_pkg::CFG_SAMPLES_ENABLE: samples_on = 1'(value);
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input int mvol, input int svol, input int men, input int sen);
        set_reg(smu_pkg::CFG_MUSIC_VOLUME, mvol);
        set_reg(smu_pkg::CFG_SAMPLE_VOLUME, svol);
        set_reg(smu_pkg::CFG_MUSIC_ENABLE, men);
        set_reg(smu_pkg::CFG_SAMPLES_ENABLE, sen);
    endtask

    // Wait until every queued item is taken and every owed result is back,
    // then let the pipeline run dry before anything touches the registers.
    // Checked at the rising edge, where the driver never moves.
    task automatic settle();
        do
            @(posedge clk);
        while (cmd_queue.size() != 0 || req_ch.valid || mix_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Request driver: bursts of random length with random gaps; a
    // quarter of the gaps are zero, giving longer back-to-back runs.
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        mixer_cmd_t nxt;
        if (!rst_n)
        begin
            req_ch.valid                <= 1'b0;
            req_ch.operation            <= smu_pkg::OP_NONE;
            req_ch.music_sample         <= '0;
            req_ch.channel_samples_low  <= '0;
            req_ch.channel_samples_high <= '0;
            req_ch.start_channel        <= '0;
            req_ch.start_length         <= '0;
            req_ch.start_level          <= '0;
        end
        else if (!req_ch.valid || req_taken)
        begin
            if (gap_left != 0 || cmd_queue.size() == 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                req_ch.valid <= 1'b0;
            end
            else
            begin
                nxt = cmd_queue.pop_front();
                req_ch.valid                <= 1'b1;
                req_ch.operation            <= nxt.op;
                req_ch.music_sample         <= nxt.music;
                req_ch.channel_samples_low  <= nxt.lanes_lo;
                req_ch.channel_samples_high <= nxt.lanes_hi;
                req_ch.start_channel        <= nxt.channel;
                req_ch.start_length         <= nxt.length;
                req_ch.start_level          <= nxt.level;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result receiver: the stall style is redrawn after a random stretch of cycles
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left  = $urandom_range(16, 160);
            end
            rx_left--;
            case (rx_style)
                RX_OPEN:   res_ch.ready <= 1'b1;
                RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_ch.ready <= ($urandom_range(0, 7) == 0);
                default:   res_ch.ready <= (rx_left % 5 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on each accepted item, check each accepted
    // result against the oldest owed one, and watch for a hang.
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        mixer_cmd_t  seen;
        mix_result_t want;
        if (!rst_n)
        begin
            req_taken    = 1'b0;
            stall_cycles = 0;
        end
        else
        begin
            req_taken = req_ch.valid && req_ch.ready;
            // predict first so a result can never overtake its own expectation
            if (req_taken)
            begin
                seen.op       = smu_pkg::op_t'(req_ch.operation);
                seen.music    = req_ch.music_sample;
                seen.lanes_lo = req_ch.channel_samples_low;
                seen.lanes_hi = req_ch.channel_samples_high;
                seen.channel  = req_ch.start_channel;
                seen.length   = req_ch.start_length;
                seen.level    = req_ch.start_level;
                apply_command(seen);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (mix_queue.size() == 0)
                begin
                    $error("unexpected item: mixed_sample %0d channels_used %b",
                           res_ch.mixed_sample, res_ch.channels_used);
                    errors++;
                end
                else
                begin
                    want = mix_queue.pop_front();
                    if (res_ch.mixed_sample !== want.sample)
                    begin
                        $error("mixed_sample: expected %0d, actual %0d",
                               want.sample, res_ch.mixed_sample);
                        errors++;
                    end
                    if (res_ch.channels_used !== want.used)
                    begin
                        $error("channels_used: expected %b, actual %b",
                               want.used, res_ch.channels_used);
                        errors++;
                    end
                end
            end
            // hang detection only counts while something is outstanding
            if (req_taken || (res_ch.valid && res_ch.ready)
                || (cmd_queue.size() == 0 && !req_ch.valid && mix_queue.size() == 0))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial
    begin
        int mvol;
        int svol;
        int men;
        int sen;

        cfg_we    = 1'b0;
        cfg_index = smu_pkg::CFG_MUSIC_VOLUME;
        cfg_data  = '0;

        fill_gain_rom();
        // state after reset
        music_vol  = 8'd255;
        sample_vol = 8'd255;
        music_on   = 1'b0;
        samples_on = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            left_count[c] = '0;
            lane_level[c] = '0;
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed: reset settings, music is off so only the channel counts
        queue_mix(16'sh7FFF, {$urandom, $urandom}, {$urandom, $urandom});
        queue_start(2, 24'd2, 3);
        queue_mix(16'sh0000, {16'h0000, 16'h7FFF, 16'h0000, 16'h0000}, 64'd0);
        settle();

        // --- directed: full gains, music on
        set_all(255, 255, 1, 1);
        queue_mix(16'sh7FFF, 64'd0, 64'd0);        // doubled music gain clamps high
        queue_mix(16'sh8000, 64'd0, 64'd0);        // and low
        queue_mix(16'sh0001, 64'd0, 64'd0);
        queue_mix(16'shFFFF, 64'd0, 64'd0);        // a negative sum
        // every channel and level; channel 0 gets a zero length and stays idle,
        // channel 7 the longest play there is
        for (int c = 0; c < CHANNELS; c++)
        begin
            queue_start(c, (c == CHANNELS - 1) ? 24'hFF_FFFF : 24'(c), c);
        end
        queue_op(smu_pkg::OP_NONE);                // unused code, ignored
        queue_mix(16'sh8000, {4{16'h8000}}, {4{16'h8000}});
        queue_mix(16'sh7FFF, {4{16'h7FFF}}, {4{16'h7FFF}});
        queue_mix(16'sh0000, 64'h0001_FFFF_0001_FFFF, 64'hFFFF_0001_FFFF_0001);
        queue_op(smu_pkg::OP_SILENCE);
        queue_mix(16'sd12345, {$urandom, $urandom}, {$urandom, $urandom});
        settle();

        // --- directed: both volumes at the bottom of the table (gain zero),
        // the channel is still consumed
        set_reg(smu_pkg::CFG_MUSIC_VOLUME, 0);
        set_reg(smu_pkg::CFG_SAMPLE_VOLUME, 0);
        queue_start(1, 24'd3, 7);
        queue_mix(16'sh8000, {$urandom, $urandom}, {$urandom, $urandom});
        queue_start(4, 24'd5, 0);
        settle();

        // --- directed: samples off; mix is music alone, starts are dropped,
        // yet silence still clears the running channels
        set_reg(smu_pkg::CFG_SAMPLES_ENABLE, 0);
        queue_mix(16'sh4000, {$urandom, $urandom}, {$urandom, $urandom});
        queue_start(6, 24'd9, 5);
        queue_op(smu_pkg::OP_SILENCE);
        settle();
        set_all(255, 255, 1, 1);
        queue_mix(16'sh2000, {$urandom, $urandom}, {$urandom, $urandom});
        settle();

        // --- directed: both sources off, output must be zero
        set_reg(smu_pkg::CFG_MUSIC_ENABLE, 0);
        set_reg(smu_pkg::CFG_SAMPLES_ENABLE, 0);
        queue_mix(16'sh7FFF, {4{16'h7FFF}}, {4{16'h7FFF}});
        settle();

        // --- random phases, the first few pinned to the extremes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    mvol = 255; svol = 255; men = 1; sen = 1;
                end
                1:
                begin
                    mvol = 0; svol = 255; men = 1; sen = 1;
                end
                2:
                begin
                    mvol = 255; svol = 0; men = 1; sen = 1;
                end
                3:
                begin
                    mvol = $urandom_range(0, 255); svol = 255; men = 1; sen = 0;
                end
                4:
                begin
                    mvol = 255; svol = $urandom_range(0, 255); men = 0; sen = 1;
                end
                default:
                begin
                    mvol = $urandom_range(0, 255);
                    svol = $urandom_range(0, 255);
                    men  = $urandom_range(0, 1);
                    sen  = ($urandom_range(0, 4) != 0);
                end
            endcase
            set_all(mvol, svol, men, sen);
            queue_random(PHASE_ITEMS);
            settle();
        end

        // any stray late item would be flagged by the monitor by now
        @(negedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
